/* rtl/rwl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reader-writer lock package
// Shared types, codes and limits for the reader-writer lock arbiter.
// ----------------------------------------------------------------------------
package rwl_pkg;

  // Fixed field widths of the request and result items.
  localparam int TID_W = 8;
  localparam int OP_W = 2;
  localparam int EV_W = 3;
  localparam int TID_RANGE = 1 << TID_W;

  // Default sizes handed to the top level.
  localparam int QUEUE_DEPTH_DEF = 32;
  localparam int MAX_THREADS_DEF = 256;

  // One exit-write wakes at most this many readers.
  localparam int RESULT_LIMIT = 32;
  localparam int CNT_W = $clog2(RESULT_LIMIT);

  // Active reader counter.
  localparam int READERS_W = 9;
  localparam logic [READERS_W-1:0] READERS_MAX = 9'd511;

  typedef enum logic [OP_W-1:0] {
    OP_ENTER_READ  = 2'd0,
    OP_ENTER_WRITE = 2'd1,
    OP_EXIT_READ   = 2'd2,
    OP_EXIT_WRITE  = 2'd3
  } op_t;

  typedef enum logic [EV_W-1:0] {
    EV_GRANT  = 3'd0,
    EV_QUEUED = 3'd1,
    EV_WOKEN  = 3'd2,
    EV_FULL   = 3'd3,
    EV_MISUSE = 3'd4
  } event_t;

  // Classified request handed from the front to the back.
  typedef struct packed {
    op_t              op;
    logic [TID_W-1:0] tid;
  } cmd_t;

  // One result item.
  typedef struct packed {
    logic [TID_W-1:0] tid;
    event_t           ev;
    logic             last;
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WAKE_WRITER,
    ST_DRAIN
  } back_state_t;

endpackage

/* rtl/reader_writer_lock_arbiter_core.sv */
`timescale 1ns / 1ps
// A request passes the front register, the command queue and the back end on its way
// to the result queue; a woken writer passes the writer wake state as well.
// Throughput: the back end takes one request a cycle while it is idle and the result
// queue has room; an exit-write that wakes queued readers then drains them one at a
// time, set by the single read port of the reader wait queue.
// Reset: synchronous, clears the lock state, both fill counts and all queues.
// ----------------------------------------------------------------------------
// Reader-writer lock arbiter core
// Writer-preference reader-writer lock with reader and writer wait queues.
// ----------------------------------------------------------------------------
module reader_writer_lock_arbiter_core #(
  parameter int QUEUE_DEPTH = rwl_pkg::QUEUE_DEPTH_DEF,
  parameter int MAX_THREADS = rwl_pkg::MAX_THREADS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  logic [rwl_pkg::OP_W-1:0]  operation,
  input  logic [rwl_pkg::TID_W-1:0] thread_id,
  output logic                      empty,
  input  logic                      pop,
  output logic [rwl_pkg::TID_W-1:0] thread_id_res,
  output logic [rwl_pkg::EV_W-1:0]  event_res,
  output logic                      last
);

  localparam int CMD_W = $bits(rwl_pkg::cmd_t);
  localparam int RES_W = $bits(rwl_pkg::res_t);

  logic              front_valid;
  rwl_pkg::cmd_t     front_cmd;
  logic              cmd_full;
  logic              cmd_empty;
  logic              cmd_pop;
  logic [CMD_W-1:0]  cmd_bits;
  rwl_pkg::cmd_t     cmd;
  logic              res_full;
  logic              res_push;
  rwl_pkg::res_t     res_in;
  logic [RES_W-1:0]  res_bits;
  rwl_pkg::res_t     res_out;

  // Request intake and classification.
  rwl_front #(
    .MAX_THREADS(MAX_THREADS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .operation(operation),
    .thread_id(thread_id),
    .cmd_valid(front_valid),
    .cmd      (front_cmd),
    .cmd_full (cmd_full)
  );

  // Command queue between front and back.
  rwl_fifo #(
    .WIDTH(CMD_W),
    .DEPTH(2)
  ) u_cmd_q (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (front_valid),
    .wr_data(front_cmd),
    .rd_en  (cmd_pop),
    .rd_data(cmd_bits),
    .full   (cmd_full),
    .empty  (cmd_empty)
  );

  assign cmd = rwl_pkg::cmd_t'(cmd_bits);

  // Lock state and wait queues.
  rwl_back #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(!cmd_empty),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res_in)
  );

  // Result queue toward the consumer.
  rwl_fifo #(
    .WIDTH(RES_W),
    .DEPTH(2)
  ) u_res_q (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (res_push),
    .wr_data(res_in),
    .rd_en  (pop),
    .rd_data(res_bits),
    .full   (res_full),
    .empty  (empty)
  );

  // Unpack the oldest result onto the ports.
  assign res_out       = rwl_pkg::res_t'(res_bits);
  assign thread_id_res = res_out.tid;
  assign event_res     = res_out.ev;
  assign last          = res_out.last;

endmodule

/* rtl/rwl_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Small register FIFO
// Decouples two sides of the lock arbiter; one write unless full and one read unless empty per cycle.
// ----------------------------------------------------------------------------
module rwl_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  // Storage is written at the tail pointer.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Pointers wrap at the depth, which need not be a power of two.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/rwl_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reader-writer lock front end
// Accepts requests, decodes the operation and reduces the thread id.
// ----------------------------------------------------------------------------
module rwl_front #(
  parameter int MAX_THREADS = rwl_pkg::MAX_THREADS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  logic [rwl_pkg::OP_W-1:0]  operation,
  input  logic [rwl_pkg::TID_W-1:0] thread_id,
  output logic                      cmd_valid,
  output rwl_pkg::cmd_t             cmd,
  input  logic                      cmd_full
);

  logic [rwl_pkg::TID_W-1:0] tid_mod_tbl [rwl_pkg::TID_RANGE];
  logic                      valid;
  logic                      accept;

  // Constant table of each id reduced modulo the thread count.
  for (genvar i = 0; i < rwl_pkg::TID_RANGE; i++) begin : g_mod
    assign tid_mod_tbl[i] = rwl_pkg::TID_W'(i % MAX_THREADS);
  end

  // The stage holds one request until the command queue takes it.
  assign full      = valid && cmd_full;
  assign accept    = push && !full;
  assign cmd_valid = valid;

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd.op  <= rwl_pkg::op_t'(operation);
      cmd.tid <= tid_mod_tbl[thread_id];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (accept) begin
      valid <= 1'b1;
    end else if (!cmd_full) begin
      valid <= 1'b0;
    end
  end

endmodule

/* rtl/rwl_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reader-writer lock back end
// Holds the lock state and both wait queues and carries out each request.
// ----------------------------------------------------------------------------
module rwl_back #(
  parameter int QUEUE_DEPTH = rwl_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  rwl_pkg::cmd_t cmd,
  output logic          cmd_pop,
  input  logic          res_full,
  output logic          res_push,
  output rwl_pkg::res_t res
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam int TW = rwl_pkg::TID_W;
  localparam int RW = rwl_pkg::READERS_W;

  rwl_pkg::back_state_t state, state_next;

  logic                    writer_active, writer_active_next;
  logic [RW-1:0]           active_readers, active_readers_next;
  logic [AW-1:0]           reader_head, reader_head_next;
  logic [AW-1:0]           reader_tail, reader_tail_next;
  logic [FW-1:0]           reader_fill, reader_fill_next;
  logic [AW-1:0]           writer_head, writer_head_next;
  logic [AW-1:0]           writer_tail, writer_tail_next;
  logic [FW-1:0]           writer_fill, writer_fill_next;
  logic [rwl_pkg::CNT_W-1:0] drain_cnt, drain_cnt_next;

  logic [TW-1:0] r_mem [QUEUE_DEPTH];
  logic [TW-1:0] w_mem [QUEUE_DEPTH];
  logic [TW-1:0] r_rd_data;
  logic [TW-1:0] w_rd_data;
  logic          r_we;
  logic          w_we;
  logic          take;
  logic          drain_done;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    wrap_inc = (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // A request is taken only when the result queue has room for its result.
  assign take = (state == rwl_pkg::ST_IDLE) && cmd_valid && !res_full;

  // The drain stops on an empty queue, the wake limit or the reader limit.
  assign drain_done = (reader_fill == FW'(1)) ||
                      (drain_cnt == rwl_pkg::CNT_W'(rwl_pkg::RESULT_LIMIT - 1)) ||
                      (active_readers == rwl_pkg::READERS_MAX - 1'b1);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      rwl_pkg::ST_IDLE: begin
        if (take) begin
          case (cmd.op)
            rwl_pkg::OP_EXIT_READ: begin
              if (active_readers == RW'(1) && writer_fill != '0 && !writer_active) begin
                state_next = rwl_pkg::ST_WAKE_WRITER;
              end
            end
            rwl_pkg::OP_EXIT_WRITE: begin
              if (writer_active) begin
                if (reader_fill != '0) begin
                  state_next = rwl_pkg::ST_DRAIN;
                end else if (writer_fill != '0) begin
                  state_next = rwl_pkg::ST_WAKE_WRITER;
                end
              end
            end
            default: begin
              state_next = rwl_pkg::ST_IDLE;
            end
          endcase
        end
      end
      rwl_pkg::ST_WAKE_WRITER: begin
        if (!res_full) begin
          state_next = rwl_pkg::ST_IDLE;
        end
      end
      rwl_pkg::ST_DRAIN: begin
        if (!res_full && drain_done) begin
          state_next = rwl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rwl_pkg::ST_IDLE;
      end
    endcase
  end

  // Results and state updates.
  always_comb begin
    writer_active_next  = writer_active;
    active_readers_next = active_readers;
    reader_head_next    = reader_head;
    reader_tail_next    = reader_tail;
    reader_fill_next    = reader_fill;
    writer_head_next    = writer_head;
    writer_tail_next    = writer_tail;
    writer_fill_next    = writer_fill;
    drain_cnt_next      = drain_cnt;
    cmd_pop             = 1'b0;
    res_push            = 1'b0;
    res.tid             = cmd.tid;
    res.ev              = rwl_pkg::EV_GRANT;
    res.last            = 1'b1;
    r_we                = 1'b0;
    w_we                = 1'b0;
    case (state)
      rwl_pkg::ST_IDLE: begin
        if (take) begin
          cmd_pop = 1'b1;
          case (cmd.op)
            rwl_pkg::OP_ENTER_READ: begin
              res_push = 1'b1;
              if (writer_active || writer_fill != '0) begin
                if (reader_fill == FW'(QUEUE_DEPTH)) begin
                  res.ev = rwl_pkg::EV_FULL;
                end else begin
                  r_we             = 1'b1;
                  reader_tail_next = wrap_inc(reader_tail);
                  reader_fill_next = reader_fill + 1'b1;
                  res.ev           = rwl_pkg::EV_QUEUED;
                end
              end else if (active_readers == rwl_pkg::READERS_MAX) begin
                res.ev = rwl_pkg::EV_FULL;
              end else begin
                active_readers_next = active_readers + 1'b1;
              end
            end
            rwl_pkg::OP_ENTER_WRITE: begin
              res_push = 1'b1;
              if (active_readers != '0 || writer_active) begin
                if (writer_fill == FW'(QUEUE_DEPTH)) begin
                  res.ev = rwl_pkg::EV_FULL;
                end else begin
                  w_we             = 1'b1;
                  writer_tail_next = wrap_inc(writer_tail);
                  writer_fill_next = writer_fill + 1'b1;
                  res.ev           = rwl_pkg::EV_QUEUED;
                end
              end else begin
                writer_active_next = 1'b1;
              end
            end
            rwl_pkg::OP_EXIT_READ: begin
              if (active_readers == '0) begin
                res_push = 1'b1;
                res.tid  = '0;
                res.ev   = rwl_pkg::EV_MISUSE;
              end else begin
                active_readers_next = active_readers - 1'b1;
              end
            end
            rwl_pkg::OP_EXIT_WRITE: begin
              if (!writer_active) begin
                res_push = 1'b1;
                res.tid  = '0;
                res.ev   = rwl_pkg::EV_MISUSE;
              end else begin
                writer_active_next = 1'b0;
                drain_cnt_next     = '0;
              end
            end
            default: begin
              cmd_pop = 1'b1;
            end
          endcase
        end
      end
      rwl_pkg::ST_WAKE_WRITER: begin
        if (!res_full) begin
          res_push           = 1'b1;
          res.tid            = w_rd_data;
          res.ev             = rwl_pkg::EV_WOKEN;
          writer_head_next   = wrap_inc(writer_head);
          writer_fill_next   = writer_fill - 1'b1;
          writer_active_next = 1'b1;
        end
      end
      rwl_pkg::ST_DRAIN: begin
        if (!res_full) begin
          res_push            = 1'b1;
          res.tid             = r_rd_data;
          res.ev              = rwl_pkg::EV_WOKEN;
          res.last            = drain_done;
          reader_head_next    = wrap_inc(reader_head);
          reader_fill_next    = reader_fill - 1'b1;
          active_readers_next = active_readers + 1'b1;
          drain_cnt_next      = drain_cnt + 1'b1;
        end
      end
      default: begin
        res_push = 1'b0;
      end
    endcase
  end

  // Wait queues: written at the tail, read ahead at the next head so the
  // registered read data holds the current front entry whenever a wake reads it.
  always_ff @(posedge clk) begin
    if (r_we) begin
      r_mem[reader_tail] <= cmd.tid;
    end
    r_rd_data <= r_mem[reader_head_next];
  end

  always_ff @(posedge clk) begin
    if (w_we) begin
      w_mem[writer_tail] <= cmd.tid;
    end
    w_rd_data <= w_mem[writer_head_next];
  end

  // Lock state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= rwl_pkg::ST_IDLE;
      writer_active  <= 1'b0;
      active_readers <= '0;
      reader_head    <= '0;
      reader_tail    <= '0;
      reader_fill    <= '0;
      writer_head    <= '0;
      writer_tail    <= '0;
      writer_fill    <= '0;
      drain_cnt      <= '0;
    end else begin
      state          <= state_next;
      writer_active  <= writer_active_next;
      active_readers <= active_readers_next;
      reader_head    <= reader_head_next;
      reader_tail    <= reader_tail_next;
      reader_fill    <= reader_fill_next;
      writer_head    <= writer_head_next;
      writer_tail    <= writer_tail_next;
      writer_fill    <= writer_fill_next;
      drain_cnt      <= drain_cnt_next;
    end
  end

  // A writer never holds the lock together with readers.
  a_exclusive: assert property (@(posedge clk) disable iff (rst)
    writer_active |-> (active_readers == '0))
    else $error("writer active while readers hold the lock");

  // Fill counts never pass the queue depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (reader_fill <= FW'(QUEUE_DEPTH)) && (writer_fill <= FW'(QUEUE_DEPTH)))
    else $error("wait queue fill count out of range");

  // A result is only produced when the result queue has room.
  a_res_room: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");

  // The reader drain only runs with readers waiting and no writer.
  a_drain_valid: assert property (@(posedge clk) disable iff (rst)
    (state == rwl_pkg::ST_DRAIN) |-> (reader_fill != '0) && !writer_active)
    else $error("reader drain with empty queue or active writer");

  // A writer is woken only from a non-empty queue onto a free lock.
  a_wake_valid: assert property (@(posedge clk) disable iff (rst)
    (state == rwl_pkg::ST_WAKE_WRITER) |->
      (writer_fill != '0) && !writer_active && (active_readers == '0))
    else $error("writer wake without a waiting writer or with the lock held");

endmodule
